>>> rtl/cursor_linked_list_table_top_assert.svh
// Assertion macros for the cursor linked list table.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef CURSOR_LINKED_LIST_TABLE_TOP_ASSERT_SVH
`define CURSOR_LINKED_LIST_TABLE_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CLL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a property on the next clock edge.
`define CLL_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> rtl/cll_pkg.sv
// Shared types and constants for the cursor linked list table.
// No dependencies.
package cll_pkg;

  localparam int DefPoolDepth = 16;
  localparam int DefValueBits = 32;
  localparam int OpBits       = 4;
  localparam int PosBits      = 4;
  localparam int CapBits      = 5;
  localparam logic [CapBits-1:0] CapReset = 5'd16;

  localparam int MaxIdxBits   = 10;
  localparam int MaxLinkBits  = 11;
  localparam int MaxValueBits = 64;

  typedef enum logic [OpBits-1:0] {
    OP_INSERT       = 4'd0,
    OP_DELETE_AT    = 4'd1,
    OP_READ_AT      = 4'd2,
    OP_FIRST        = 4'd3,
    OP_LAST         = 4'd4,
    OP_NEXT         = 4'd5,
    OP_PREV         = 4'd6,
    OP_READ_CURRENT = 4'd7,
    OP_CLEAR        = 4'd8
  } op_t;

  typedef struct packed {
    logic                    new_en;
    logic [MaxIdxBits-1:0]   new_idx;
    logic [MaxValueBits-1:0] new_value;
    logic [MaxLinkBits-1:0]  new_next;
    logic [MaxLinkBits-1:0]  new_prev;
    logic                    next_en;
    logic [MaxIdxBits-1:0]   next_idx;
    logic [MaxLinkBits-1:0]  next_data;
    logic                    prev_en;
    logic [MaxIdxBits-1:0]   prev_idx;
    logic [MaxLinkBits-1:0]  prev_data;
    logic                    clr_en;
    logic [MaxIdxBits-1:0]   clr_idx;
    logic                    clr_all;
  } cll_wr_t;

endpackage

>>> rtl/cll_cell.sv
// One pool slot: value, forward and backward links, and in-use flag.
// Depends on cll_pkg for the write command struct.
module cll_cell import cll_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits,
  parameter int SLOT_BITS  = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cll_wr_t               wr,
  output logic [VALUE_BITS-1:0] value,
  output logic [SLOT_BITS-1:0]  next_link,
  output logic [SLOT_BITS-1:0]  prev_link,
  output logic                  used
);

  localparam logic [MaxIdxBits-1:0] MyIdx = MaxIdxBits'(INDEX);

  logic hit_new, hit_next, hit_prev, hit_clr;

  assign hit_new  = wr.new_en  && (wr.new_idx  == MyIdx);
  assign hit_next = wr.next_en && (wr.next_idx == MyIdx);
  assign hit_prev = wr.prev_en && (wr.prev_idx == MyIdx);
  assign hit_clr  = wr.clr_en  && (wr.clr_idx  == MyIdx);

  always_ff @(posedge clk) begin
    if (hit_new) begin
      value     <= wr.new_value[VALUE_BITS-1:0];
      next_link <= wr.new_next[SLOT_BITS-1:0];
      prev_link <= wr.new_prev[SLOT_BITS-1:0];
    end
    if (hit_next) begin
      next_link <= wr.next_data[SLOT_BITS-1:0];
    end
    if (hit_prev) begin
      prev_link <= wr.prev_data[SLOT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clr_all || hit_clr) begin
      used <= 1'b0;
    end else if (hit_new) begin
      used <= 1'b1;
    end
  end

endmodule

>>> rtl/cursor_linked_list_table_top.sv
// Cursor linked list table: top level with the slot cells and the list controller.
// Depends on cll_pkg, cll_cell and cursor_linked_list_table_top_assert.svh.
//
// A doubly linked list of values kept in a row of POOL_DEPTH slot cells, one item
// at a time. Every item ends in a result state that holds until out_ready. Cursor
// moves, read_current, clear and failed operations go straight to the result.
// Read_at and delete_at walk the links one element per cycle to the position.
// Insert then scans the in-use flags one slot per cycle for the next free slot.
module cursor_linked_list_table_top import cll_pkg::*; #(
  parameter int POOL_DEPTH = DefPoolDepth,
  parameter int VALUE_BITS = DefValueBits,
  localparam int SW = $clog2(POOL_DEPTH + 1),
  localparam int IW = $clog2(POOL_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CapBits-1:0]    cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OpBits-1:0]     opcode,
  input  logic [VALUE_BITS-1:0] value_in,
  input  logic [PosBits-1:0]    position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  ok,
  output logic [VALUE_BITS-1:0] value_out,
  output logic [SW-1:0]         count,
  output logic                  cursor_valid,
  output logic                  at_first,
  output logic                  at_last,
  output logic                  is_full,
  output logic                  is_empty
);

  `include "cursor_linked_list_table_top_assert.svh"

  localparam logic [SW-1:0] NoneSlot = SW'(POOL_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_SCAN, S_RESP} state_t;

  state_t               state;
  logic [CapBits-1:0]   cap;
  logic [SW-1:0]        head_slot, tail_slot, cursor_slot, elem_count, free_slot;
  logic [SW-1:0]        walk_slot, scan;
  logic [PosBits-1:0]   walk_left;
  op_t                  op_q;
  logic                 ok_q;
  logic [VALUE_BITS-1:0] rd_q;

  logic [VALUE_BITS-1:0] cell_value [POOL_DEPTH];
  logic [SW-1:0]         cell_next  [POOL_DEPTH];
  logic [SW-1:0]         cell_prev  [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] cell_used;
  cll_wr_t               wr;

  logic [SW-1:0] eff_cap;
  logic          accept, can_insert, pos_ok, cur_ok, head_ok, tail_ok;
  logic [SW-1:0] n_of_cur;
  logic [SW-1:0] walk_next, walk_prev;

  genvar g;
  generate
    for (g = 0; g < POOL_DEPTH; g++) begin : gen_cell
      cll_cell #(.VALUE_BITS(VALUE_BITS), .SLOT_BITS(SW), .INDEX(g)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .wr        (wr),
        .value     (cell_value[g]),
        .next_link (cell_next[g]),
        .prev_link (cell_prev[g]),
        .used      (cell_used[g])
      );
    end
  endgenerate

  always_comb begin
    if (cap == '0) begin
      eff_cap = SW'(1);
    end else if (int'(cap) > POOL_DEPTH) begin
      eff_cap = NoneSlot;
    end else begin
      eff_cap = SW'(cap);
    end
  end

  assign accept     = in_valid && in_ready;
  assign cur_ok     = cursor_slot != NoneSlot;
  assign head_ok    = head_slot != NoneSlot;
  assign tail_ok    = tail_slot != NoneSlot;
  assign can_insert = (elem_count < eff_cap) && (free_slot != NoneSlot);
  assign pos_ok     = int'(position) < int'(elem_count);
  assign n_of_cur   = cell_next[cursor_slot[IW-1:0]];
  assign walk_next  = cell_next[walk_slot[IW-1:0]];
  assign walk_prev  = cell_prev[walk_slot[IW-1:0]];

  always_comb begin
    wr = '0;
    if (state == S_IDLE && accept) begin
      if (opcode == OP_INSERT && can_insert) begin
        wr.new_en    = 1'b1;
        wr.new_idx   = MaxIdxBits'(free_slot[IW-1:0]);
        wr.new_value = MaxValueBits'(value_in);
        if (elem_count == '0 || !head_ok) begin
          wr.new_next = MaxLinkBits'(NoneSlot);
          wr.new_prev = MaxLinkBits'(NoneSlot);
        end else if (cur_ok) begin
          wr.new_next  = MaxLinkBits'(n_of_cur);
          wr.new_prev  = MaxLinkBits'(cursor_slot);
          wr.prev_en   = n_of_cur != NoneSlot;
          wr.prev_idx  = MaxIdxBits'(n_of_cur[IW-1:0]);
          wr.prev_data = MaxLinkBits'(free_slot);
          wr.next_en   = 1'b1;
          wr.next_idx  = MaxIdxBits'(cursor_slot[IW-1:0]);
          wr.next_data = MaxLinkBits'(free_slot);
        end else begin
          wr.new_next  = MaxLinkBits'(head_slot);
          wr.new_prev  = MaxLinkBits'(NoneSlot);
          wr.prev_en   = 1'b1;
          wr.prev_idx  = MaxIdxBits'(head_slot[IW-1:0]);
          wr.prev_data = MaxLinkBits'(free_slot);
        end
      end
      if (opcode == OP_CLEAR) begin
        wr.clr_all = 1'b1;
      end
    end
    if (state == S_WALK && walk_left == '0 && op_q == OP_DELETE_AT) begin
      wr.next_en   = walk_prev != NoneSlot;
      wr.next_idx  = MaxIdxBits'(walk_prev[IW-1:0]);
      wr.next_data = MaxLinkBits'(walk_next);
      wr.prev_en   = walk_next != NoneSlot;
      wr.prev_idx  = MaxIdxBits'(walk_next[IW-1:0]);
      wr.prev_data = MaxLinkBits'(walk_prev);
      wr.clr_en    = 1'b1;
      wr.clr_idx   = MaxIdxBits'(walk_slot[IW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CapReset;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_slot   <= NoneSlot;
      tail_slot   <= NoneSlot;
      cursor_slot <= NoneSlot;
      elem_count  <= '0;
      free_slot   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= op_t'(opcode);
            ok_q  <= 1'b0;
            rd_q  <= '0;
            state <= S_RESP;
            case (opcode)
              OP_INSERT: begin
                if (can_insert) begin
                  ok_q        <= 1'b1;
                  cursor_slot <= free_slot;
                  elem_count  <= elem_count + SW'(1);
                  scan        <= free_slot + SW'(1);
                  state       <= S_SCAN;
                  if (elem_count == '0 || !head_ok) begin
                    head_slot <= free_slot;
                    tail_slot <= free_slot;
                  end else if (cur_ok) begin
                    if (n_of_cur == NoneSlot) begin
                      tail_slot <= free_slot;
                    end
                  end else begin
                    head_slot <= free_slot;
                  end
                end
              end
              OP_DELETE_AT, OP_READ_AT: begin
                if (pos_ok) begin
                  walk_slot <= head_slot;
                  walk_left <= position;
                  state     <= S_WALK;
                end
              end
              OP_FIRST: begin
                cursor_slot <= head_slot;
                ok_q        <= elem_count != '0;
              end
              OP_LAST: begin
                cursor_slot <= tail_slot;
                ok_q        <= elem_count != '0;
              end
              OP_NEXT: begin
                if (cur_ok) begin
                  cursor_slot <= n_of_cur;
                end else if (head_ok) begin
                  cursor_slot <= cell_next[head_slot[IW-1:0]];
                end else begin
                  cursor_slot <= NoneSlot;
                end
                ok_q <= elem_count != '0;
              end
              OP_PREV: begin
                if (cur_ok) begin
                  cursor_slot <= cell_prev[cursor_slot[IW-1:0]];
                end else if (tail_ok) begin
                  cursor_slot <= cell_prev[tail_slot[IW-1:0]];
                end else begin
                  cursor_slot <= NoneSlot;
                end
                ok_q <= elem_count != '0;
              end
              OP_READ_CURRENT: begin
                if (cur_ok) begin
                  ok_q <= 1'b1;
                  rd_q <= cell_value[cursor_slot[IW-1:0]];
                end
              end
              OP_CLEAR: begin
                head_slot   <= NoneSlot;
                tail_slot   <= NoneSlot;
                cursor_slot <= NoneSlot;
                elem_count  <= '0;
                free_slot   <= '0;
                ok_q        <= 1'b1;
              end
              default: begin
                ok_q <= 1'b0;
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_left == '0) begin
            ok_q  <= 1'b1;
            state <= S_RESP;
            if (op_q == OP_READ_AT) begin
              rd_q <= cell_value[walk_slot[IW-1:0]];
            end else begin
              if (walk_prev == NoneSlot) begin
                head_slot <= walk_next;
              end
              if (walk_next == NoneSlot) begin
                tail_slot <= walk_prev;
              end
              if (cursor_slot == walk_slot) begin
                cursor_slot <= walk_next;
              end
              elem_count <= elem_count - SW'(1);
              if (walk_slot < free_slot) begin
                free_slot <= walk_slot;
              end
            end
          end else begin
            walk_slot <= walk_next;
            walk_left <= walk_left - PosBits'(1);
          end
        end
        S_SCAN: begin
          if (scan == NoneSlot) begin
            free_slot <= NoneSlot;
            state     <= S_RESP;
          end else if (!cell_used[scan[IW-1:0]]) begin
            free_slot <= scan;
            state     <= S_RESP;
          end else begin
            scan <= scan + SW'(1);
          end
        end
        S_RESP: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready     = state == S_IDLE;
  assign out_valid    = state == S_RESP;
  assign ok           = ok_q;
  assign value_out    = rd_q;
  assign count        = elem_count;
  assign cursor_valid = cur_ok;
  assign at_first     = cur_ok && (cursor_slot == head_slot);
  assign at_last      = cur_ok && (cursor_slot == tail_slot);
  assign is_full      = elem_count >= eff_cap;
  assign is_empty     = elem_count == '0;

  `CLL_ASSERT(a_count_bound, elem_count <= NoneSlot, "element count above pool depth")
  `CLL_ASSERT(a_head_empty, (head_slot == NoneSlot) == (elem_count == '0), "head and count disagree")
  `CLL_ASSERT(a_cursor_nonempty, !cur_ok || elem_count != '0, "cursor on an empty list")
  `CLL_ASSERT_NEXT(a_resp_hold, out_valid && !out_ready, out_valid && $stable(ok_q), "result dropped")

endmodule

>>> test/cll_checker.sv
`timescale 1ns / 100ps
// Checker for the cursor linked list table: watches both channels, keeps its own
// list state, predicts each result and compares it. Depends on cll_pkg.
module cll_checker import cll_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [31:0] value_in,
  input  logic [3:0]  position,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        ok,
  input  logic [31:0] value_out,
  input  logic [4:0]  count,
  input  logic        cursor_valid,
  input  logic        at_first,
  input  logic        at_last,
  input  logic        is_full,
  input  logic        is_empty,
  output int          errors,
  output int          pending
);
  localparam logic [4:0] NIL = 5'd16;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
    logic [4:0]  count;
    logic        cv;
    logic        first;
    logic        last;
    logic        full;
    logic        empty;
  } status_t;

  logic [31:0] vals [16];
  logic [4:0]  nxt  [16];
  logic [4:0]  prv  [16];
  logic        used [16];
  logic [4:0]  head, tail, cur, cnt, cap;
  status_t     status_q[$];

  assign pending = status_q.size();

  function automatic logic [4:0] eff_cap();
    if (cap == 0) return 5'd1;
    if (cap > 16) return 5'd16;
    return cap;
  endfunction

  function automatic logic [4:0] lowest_free();
    for (int i = 0; i < 16; i++) if (!used[i]) return i[4:0];
    return NIL;
  endfunction

  function automatic logic [4:0] slot_at(logic [3:0] pos);
    logic [4:0] s;
    s = head;
    if ({1'b0, pos} >= cnt) return NIL;
    for (int i = 0; i < pos; i++) begin
      if (s == NIL) return NIL;
      s = nxt[s[3:0]];
    end
    return s;
  endfunction

  task automatic apply_op(logic [3:0] op, logic [31:0] v, logic [3:0] pos);
    status_t r;
    logic [4:0] s, p, n;
    r = '0;
    case (op)
      OP_INSERT: begin
        s = lowest_free();
        if (cnt < eff_cap() && s != NIL) begin
          vals[s[3:0]] = v;
          used[s[3:0]] = 1'b1;
          if (cnt == 0 || head == NIL) begin
            nxt[s[3:0]] = NIL; prv[s[3:0]] = NIL; head = s; tail = s;
          end else if (cur != NIL) begin
            n = nxt[cur[3:0]];
            nxt[s[3:0]] = n; prv[s[3:0]] = cur;
            if (n != NIL) prv[n[3:0]] = s; else tail = s;
            nxt[cur[3:0]] = s;
          end else begin
            nxt[s[3:0]] = head; prv[s[3:0]] = NIL; prv[head[3:0]] = s; head = s;
          end
          cur = s;
          cnt++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE_AT: begin
        s = slot_at(pos);
        if (s != NIL) begin
          p = prv[s[3:0]]; n = nxt[s[3:0]];
          if (p != NIL) nxt[p[3:0]] = n; else head = n;
          if (n != NIL) prv[n[3:0]] = p; else tail = p;
          if (cur == s) cur = n;
          used[s[3:0]] = 1'b0;
          cnt--;
          r.ok = 1'b1;
        end
      end
      OP_READ_AT: begin
        s = slot_at(pos);
        if (s != NIL) begin r.ok = 1'b1; r.value = vals[s[3:0]]; end
      end
      OP_FIRST: begin cur = head; r.ok = cnt != 0; end
      OP_LAST: begin cur = tail; r.ok = cnt != 0; end
      OP_NEXT: begin
        if (cur == NIL) cur = head;
        cur = (cur != NIL) ? nxt[cur[3:0]] : NIL;
        r.ok = cnt != 0;
      end
      OP_PREV: begin
        if (cur == NIL) cur = tail;
        cur = (cur != NIL) ? prv[cur[3:0]] : NIL;
        r.ok = cnt != 0;
      end
      OP_READ_CURRENT: begin
        if (cur != NIL) begin r.ok = 1'b1; r.value = vals[cur[3:0]]; end
      end
      OP_CLEAR: begin
        for (int i = 0; i < 16; i++) used[i] = 1'b0;
        head = NIL; tail = NIL; cur = NIL; cnt = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = cnt;
    r.cv    = cur != NIL;
    r.first = r.cv && cur == head;
    r.last  = r.cv && cur == tail;
    r.full  = cnt >= eff_cap();
    r.empty = cnt == 0;
    status_q.push_back(r);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    status_t e;
    if (rst) begin
      for (int i = 0; i < 16; i++) used[i] = 1'b0;
      head = NIL; tail = NIL; cur = NIL; cnt = 0; cap = CapReset;
      errors = 0;
    end else begin
      if (cfg_we) cap = cfg_wdata;
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          e = status_q.pop_front();
          if (ok !== e.ok) report("ok", ok, e.ok);
          if (value_out !== e.value) report("value_out", value_out, e.value);
          if (count !== e.count) report("count", count, e.count);
          if (cursor_valid !== e.cv) report("cursor_valid", cursor_valid, e.cv);
          if (at_first !== e.first) report("at_first", at_first, e.first);
          if (at_last !== e.last) report("at_last", at_last, e.last);
          if (is_full !== e.full) report("is_full", is_full, e.full);
          if (is_empty !== e.empty) report("is_empty", is_empty, e.empty);
        end
      end
      if (in_valid && in_ready) apply_op(opcode, value_in, position);
    end
  end
endmodule

>>> test/tb_cursor_linked_list_table_top.sv
`timescale 1ns / 100ps
// Testbench top for the cursor linked list table: makes stimulus and idling,
// gives the verdict. Depends on cll_pkg, cll_checker and the block.
module tb_cursor_linked_list_table_top import cll_pkg::*;;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  opcode = '0;
  logic [31:0] value_in = '0;
  logic [3:0]  position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok, cursor_valid, at_first, at_last, is_full, is_empty;
  logic [31:0] value_out;
  logic [4:0]  count;
  int          errors, pending;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_sink = 1'b0;
  logic [4:0]  cap_now = 5'd16;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cursor_linked_list_table_top uut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .opcode, .value_in,
    .position, .out_valid, .out_ready, .ok, .value_out, .count, .cursor_valid,
    .at_first, .at_last, .is_full, .is_empty
  );

  cll_checker chk (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .opcode, .value_in,
    .position, .out_valid, .out_ready, .ok, .value_out, .count, .cursor_valid,
    .at_first, .at_last, .is_full, .is_empty, .errors, .pending
  );

  // receiver: random stall bursts, none when calm or held off
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // drop valid at the transfer edge; the block is busy on the following edge
  task automatic send(logic [3:0] op, logic [31:0] v, logic [3:0] pos);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value_in <= v;
    position <= pos;
    @(posedge clk iff in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk iff pending == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_cap(logic [4:0] c);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    cap_now = c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_op(int pos_span);
    int r;
    logic [3:0] op;
    r = $urandom_range(0, 99);
    if (r < 35)      op = OP_INSERT;
    else if (r < 50) op = OP_DELETE_AT;
    else if (r < 62) op = OP_READ_AT;
    else if (r < 96) op = 4'($urandom_range(OP_FIRST, OP_READ_CURRENT));
    else if (r < 98) op = OP_CLEAR;
    else             op = 4'($urandom_range(9, 15));
    send(op, $urandom, 4'($urandom_range(0, pos_span)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty list, extremes, fill to full, overflow, deletes
    send(OP_READ_CURRENT, 0, 0);
    send(OP_NEXT, 0, 0);
    send(OP_PREV, 0, 0);
    send(OP_DELETE_AT, 0, 0);
    send(OP_INSERT, 32'hFFFF_FFFF, 0);
    send(OP_INSERT, 32'h0, 0);
    send(OP_FIRST, 0, 0);
    send(OP_INSERT, 32'hA5A5_5A5A, 0);
    for (int i = 0; i < 14; i++) send(OP_INSERT, $urandom, 0);
    send(OP_READ_AT, 0, 4'd15);
    send(OP_DELETE_AT, 0, 4'd15);
    send(OP_LAST, 0, 0);
    send(OP_NEXT, 0, 0);
    send(OP_PREV, 0, 0);
    send(OP_DELETE_AT, 0, 0);
    send(4'd15, 0, 0);
    send(OP_CLEAR, 0, 0);
    // capacity extremes, including out of range and lowered below count
    set_cap(5'd0);
    send(OP_INSERT, $urandom, 0);
    send(OP_INSERT, $urandom, 0);
    set_cap(5'd31);
    for (int i = 0; i < 5; i++) send(OP_INSERT, $urandom, 0);
    set_cap(5'd3);
    send(OP_INSERT, $urandom, 0);
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 12; i++) send(OP_READ_AT, 0, 4'($urandom_range(0, 7)));
    join
    drain();
    // random phases across capacities
    for (int ph = 0; ph < 6; ph++) begin
      set_cap(ph == 0 ? 5'd1 : ph == 1 ? 5'd16 : 5'($urandom_range(1, 16)));
      for (int i = 0; i < 100; i++) random_op(cap_now > 1 ? 15 : 3);
    end
    calm = 1'b1;
    set_cap(5'd16);
    for (int i = 0; i < 60; i++) random_op(15);
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
